/* src/srce_pkg.sv */
// Shared constants and types for the sorted rank count engine.
`default_nettype none

package srce_pkg;

    localparam int MAX_ELEMS = 1024;
    localparam int VAL_W     = 32;
    localparam int OUT_W     = 11;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int POS_W     = $clog2(CNT_W);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RANK = 1'b1
    } state_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                    clear;
        logic                    load;
        logic                    query;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } rank_status_t;

endpackage

`default_nettype wire

/* src/sorted_rank_count_engine.sv */
// Top level: sorted insertion chain with rank queries on the stored values.
//
// Usage:
//   Input channel (in_valid / in_stall, func, item_value). func selects
//   clear (empties the store), load (inserts item_value at its sorted place)
//   or rank query. Any other func code is taken and ignored.
//   Output channel (out_valid / out_stall, count_not_above): one item per
//   query, the number of stored values <= the query value.
// Flow:
//   Clears and loads are taken back to back; a load into a full store is
//   dropped. A query captures a compare of every cell into the cells' le
//   registers, then the search unit resolves the count one bit per cycle,
//   from the top bit down; the result is written to the output register
//   once the search is done and the register is free, and the input reopens
//   in the cycle after that, so no new item is taken while a query is open.
// Reset: the chain is emptied at once (per-cell valid flags), no result is
//   pending and the input is open in the first cycle after reset.
// Stall: a waiting result sits in the output register; loads and clears go
//   on meanwhile, and a following query holds off the input only until its
//   own count can be written.
`default_nettype none

module sorted_rank_count_engine (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [1:0]                            func,
    input  wire logic signed [srce_pkg::VAL_W-1:0]     item_value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [srce_pkg::OUT_W-1:0]                 count_not_above
);

    localparam int N = srce_pkg::MAX_ELEMS;

    srce_pkg::state_t        state_reg, state_next;
    srce_pkg::cell_cmd_t     cmd;
    srce_pkg::rank_status_t  rank_st;

    logic                                in_accept;
    logic                                full;
    logic                                out_free;
    logic                                out_load;
    logic                                out_valid_reg, out_valid_next;
    logic [srce_pkg::OUT_W-1:0]          count_reg, count_next;

    logic [N-1:0]                        gt_w;
    logic [N-1:0]                        valid_w;
    logic [N-1:0]                        le_w;
    logic signed [srce_pkg::VAL_W-1:0]   value_w [N];

    assign in_accept = in_valid && !in_stall;
    // cells fill from the low end, so the last cell tells full
    assign full      = valid_w[N-1];

    assign cmd.clear = in_accept && (func == srce_pkg::FUNC_CLEAR);
    assign cmd.load  = in_accept && (func == srce_pkg::FUNC_LOAD) && !full;
    assign cmd.query = in_accept && (func == srce_pkg::FUNC_QUERY);
    assign cmd.value = item_value;

    // Insertion chain: each cell sees its lower neighbor.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            srce_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_gt    (1'b0),
                .prev_valid (1'b0),
                .prev_value ('0),
                .gt         (gt_w[i]),
                .valid      (valid_w[i]),
                .value      (value_w[i]),
                .le         (le_w[i])
            );
        end
        else
        begin : g_body
            srce_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_gt    (gt_w[i-1]),
                .prev_valid (valid_w[i-1]),
                .prev_value (value_w[i-1]),
                .gt         (gt_w[i]),
                .valid      (valid_w[i]),
                .value      (value_w[i]),
                .le         (le_w[i])
            );
        end
    end

    srce_rank u_rank (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.query),
        .le_vec (le_w),
        .status (rank_st)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srce_pkg::ST_IDLE:
            begin
                if (cmd.query)
                begin
                    state_next = srce_pkg::ST_RANK;
                end
            end
            srce_pkg::ST_RANK:
            begin
                if (!rank_st.busy && out_free)
                begin
                    state_next = srce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srce_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        unique case (state_reg)
            srce_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            srce_pkg::ST_RANK:
            begin
                out_load = !rank_st.busy && out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);
    assign count_next     = out_load ? srce_pkg::OUT_W'(rank_st.count) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srce_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign out_valid       = out_valid_reg;
    assign count_not_above = count_reg;

    // A new result only comes out of a finished search.
    a_out_from_rank: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == srce_pkg::ST_RANK))
        else $error("result raised without a search");

    // The input never opens while a search is running.
    a_open_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !rank_st.busy)
        else $error("input open during search");

    // A taken query starts the search unit.
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.query |=> rank_st.busy)
        else $error("query did not start search");

    // Occupied cells form a contiguous run from the head of the chain.
    a_chain_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_w} + (N+1)'(1)))
        else $error("chain occupancy has a gap");

endmodule

`default_nettype wire

/* src/srce_cell.sv */
// One cell of the sorted insertion chain: holds one value, shifts on insert.
`default_nettype none

module srce_cell (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire srce_pkg::cell_cmd_t                     cmd,
    input  wire logic                                    prev_gt,
    input  wire logic                                    prev_valid,
    input  wire logic signed [srce_pkg::VAL_W-1:0]       prev_value,
    output logic                                         gt,
    output logic                                         valid,
    output logic signed [srce_pkg::VAL_W-1:0]            value,
    output logic                                         le
);

    logic                                valid_reg, valid_next;
    logic                                le_reg, le_next;
    logic signed [srce_pkg::VAL_W-1:0]   value_reg, value_next;

    // Empty cells count as greater, so the chain stays a thermometer.
    assign gt = !valid_reg || (value_reg > cmd.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        le_next    = le_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.load && gt)
        begin
            if (!prev_gt)
            begin
                // insertion point
                value_next = cmd.value;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
        end
        if (cmd.query)
        begin
            le_next = !gt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            le_reg    <= le_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign le    = le_reg;

endmodule

`default_nettype wire

/* src/srce_rank.sv */
// Bit-per-cycle binary search that turns the captured thermometer into a count.
`default_nettype none

module srce_rank (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [srce_pkg::MAX_ELEMS-1:0]     le_vec,
    output srce_pkg::rank_status_t                  status
);

    logic                          busy_reg, busy_next;
    logic [srce_pkg::CNT_W-1:0]    acc_reg, acc_next;
    logic [srce_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [srce_pkg::CNT_W-1:0]    cand;
    logic [srce_pkg::CNT_W-1:0]    cand_m1;
    logic                          in_range;
    logic                          hit;

    assign cand     = acc_reg | (srce_pkg::CNT_W'(1) << pos_reg);
    assign cand_m1  = cand - srce_pkg::CNT_W'(1);
    assign in_range = (cand <= srce_pkg::CNT_W'(srce_pkg::MAX_ELEMS));
    assign hit      = in_range && le_vec[cand_m1[srce_pkg::IDX_W-1:0]];

    always_comb
    begin
        busy_next = busy_reg;
        acc_next  = acc_reg;
        pos_next  = pos_reg;
        if (start)
        begin
            busy_next = 1'b1;
            acc_next  = '0;
            pos_next  = srce_pkg::POS_W'(srce_pkg::CNT_W - 1);
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                acc_next = cand;
            end
            if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - srce_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        pos_reg <= pos_next;
    end

    assign status.busy  = busy_reg;
    assign status.count = acc_reg;

endmodule

`default_nettype wire

/* dv/sorted_rank_count_engine_tb.sv */
// Self-checking testbench for the sorted rank count engine.
`timescale 1ns / 100ps

module sorted_rank_count_engine_tb;
    import srce_pkg::*;

    // func code the block must take and ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Cycles with no handshake on either side before the run is declared hung.
    // Worst legal stretch: a sender gap, a query search and a long receiver stall.
    localparam int WATCHDOG_LIMIT = 1000;
    // Extra wait once nothing is owed, to catch stray results.
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 750;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              func;
    logic signed [VAL_W-1:0] item_value;
    logic                    out_valid;
    logic                    out_stall;
    logic [OUT_W-1:0]        count_not_above;

    sorted_rank_count_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .item_value      (item_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .count_not_above (count_not_above)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own sorted copy of the store, plus the counts
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] held_vals[$];
    logic [OUT_W-1:0]        rank_expect[$];

    int fail_count;
    int results_seen;
    int loads_taken;
    int queries_taken;
    int clears_taken;
    int unused_taken;
    int full_drops;
    int peak_depth;

    // sender burst bookkeeping
    int burst_left;

    // receiver stall pattern
    int stall_mode;
    int mode_left;

    int idle_cycles;

    always #5 clk = ~clk;

    // Number of held values <= v. The copy is kept sorted, so count the prefix.
    function automatic int unsigned rank_of(logic signed [VAL_W-1:0] v);
        int unsigned n;
        n = 0;
        while (n < held_vals.size() && held_vals[n] <= v)
            n++;
        return n;
    endfunction

    // Update the predicted store for one accepted item.
    task automatic apply_item(logic [1:0] f, logic signed [VAL_W-1:0] v);
        int unsigned pos;
        case (f)
            FUNC_CLEAR:
            begin
                held_vals.delete();
                clears_taken++;
            end
            FUNC_LOAD:
            begin
                loads_taken++;
                if (held_vals.size() >= MAX_ELEMS)
                begin
                    full_drops++;   // dropped silently by the block
                end
                else
                begin
                    pos = rank_of(v);
                    held_vals.insert(pos, v);
                    if (held_vals.size() > peak_depth)
                        peak_depth = held_vals.size();
                end
            end
            FUNC_QUERY:
            begin
                queries_taken++;
                rank_expect.push_back(OUT_W'(rank_of(v)));
            end
            default:
            begin
                unused_taken++;
            end
        endcase
    endtask

    // Send one item. Called and returns at a falling edge; valid is left high
    // so the next call can follow back to back, or a gap drops it.
    task automatic send_item(logic [1:0] f, logic signed [VAL_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            // every so often a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid   = 1'b1;
        func       = f;
        item_value = v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_item(f, v);
        burst_left--;
        @(negedge clk);
    endtask

    // Hold the input idle until every owed count has come back.
    task automatic wait_results_drained();
        in_valid = 1'b0;
        while (rank_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mix of full-range, clustered and extreme values; clustering gives ties.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return VAL_W'(int'($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                           : VAL_MAX - $urandom_range(0, 3);
            default: return VAL_W'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Query values: often a held value or its neighbor, to hit the <= edge.
    function automatic logic signed [VAL_W-1:0] pick_query();
        if (held_vals.size() != 0 && $urandom_range(0, 1) == 0)
            return held_vals[$urandom_range(0, held_vals.size() - 1)]
                   + VAL_W'(int'($urandom_range(0, 2)) - 1);
        return pick_value();
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries on an empty store must all rank 0.
    task automatic test_empty_store();
        send_item(FUNC_QUERY, VAL_MIN);
        send_item(FUNC_QUERY, 32'sd0);
        send_item(FUNC_QUERY, VAL_MAX);
    endtask

    // Signed extremes, ties, and queries right at each boundary.
    task automatic test_value_extremes();
        send_item(FUNC_LOAD, VAL_MAX);
        send_item(FUNC_LOAD, VAL_MIN);
        send_item(FUNC_LOAD, -32'sd1);
        send_item(FUNC_LOAD, 32'sd0);
        send_item(FUNC_LOAD, 32'sd5);
        send_item(FUNC_LOAD, 32'sd5);
        send_item(FUNC_LOAD, 32'sd5);
        send_item(FUNC_QUERY, VAL_MIN);
        send_item(FUNC_QUERY, -32'sd1);
        send_item(FUNC_QUERY, 32'sd4);
        send_item(FUNC_QUERY, 32'sd5);
        send_item(FUNC_QUERY, VAL_MAX - 32'sd1);
        send_item(FUNC_QUERY, VAL_MAX);
    endtask

    // func 3 must change nothing; then clear must empty the store.
    task automatic test_unused_func_and_clear();
        send_item(FUNC_UNUSED, VAL_MIN);
        send_item(FUNC_UNUSED, VAL_MAX);
        send_item(FUNC_QUERY, VAL_MAX);
        send_item(FUNC_CLEAR, 32'sh5A5A_A5A5);
        send_item(FUNC_QUERY, VAL_MAX);
    endtask

    // Fill to capacity, check that an extra load is dropped and that the
    // full count (top bit of the result) comes back.
    task automatic test_full_store();
        send_item(FUNC_LOAD, VAL_MIN);
        send_item(FUNC_LOAD, VAL_MAX);
        for (int i = 2; i < MAX_ELEMS; i++)
            send_item(FUNC_LOAD, pick_value());
        send_item(FUNC_QUERY, VAL_MAX);
        // at capacity: this must not land in the store
        send_item(FUNC_LOAD, VAL_MIN);
        send_item(FUNC_QUERY, VAL_MIN);
        send_item(FUNC_UNUSED, 32'sd0);
        for (int i = 0; i < 6; i++)
            send_item(FUNC_QUERY, pick_query());
        send_item(FUNC_QUERY, VAL_MAX);
        wait_results_drained();
        send_item(FUNC_CLEAR, 32'sd0);
        send_item(FUNC_QUERY, VAL_MAX);
    endtask

    // Mostly loads and queries on small stores, with occasional clears,
    // ignored codes and full pauses of the sender.
    task automatic test_random_mix();
        int roll;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                send_item(FUNC_LOAD, pick_value());
            else if (roll < 92)
                send_item(FUNC_QUERY, pick_query());
            else if (roll < 97)
                send_item(FUNC_CLEAR, $urandom);
            else
                send_item(FUNC_UNUSED, $urandom);
            if ($urandom_range(0, 99) == 0)
                wait_results_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: each taken count against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        logic [OUT_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (rank_expect.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result count_not_above=%0d",
                             $realtime, count_not_above);
            end
            else
            begin
                want = rank_expect.pop_front();
                if (count_not_above !== want)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: count_not_above expected %0d got %0d",
                                 $realtime, want, count_not_above);
                end
            end
        end
    end

    // Receiver: stretches with no stall, light random stall, heavy stall.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Watchdog: no handshake on either channel for too long means a hang.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_rank_count_engine verification failed");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_CLEAR;
        item_value    = '0;
        out_stall     = 1'b0;
        fail_count    = 0;
        results_seen  = 0;
        loads_taken   = 0;
        queries_taken = 0;
        clears_taken  = 0;
        unused_taken  = 0;
        full_drops    = 0;
        peak_depth    = 0;
        burst_left    = 0;
        stall_mode    = 0;
        mode_left     = 0;
        idle_cycles   = 0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_value_extremes();
        test_unused_func_and_clear();
        // sender holds off until everything owed has come back
        wait_results_drained();
        test_full_store();
        wait_results_drained();
        send_item(FUNC_CLEAR, 32'sd0);
        test_random_mix();
        wait_results_drained();

        // anything still owed is a missing result
        fail_count += rank_expect.size();

        $display("Covered %0d loads (%0d dropped at capacity), %0d queries, %0d clears,",
                 loads_taken, full_drops, queries_taken, clears_taken);
        $display("%0d ignored codes; %0d results checked, deepest store %0d values.",
                 unused_taken, results_seen, peak_depth);
        if (fail_count == 0)
            $display("sorted_rank_count_engine verification clean");
        else
            $display("sorted_rank_count_engine verification failed");
        $finish;
    end

endmodule
